// ===== src/dsd_pkg.sv =====
// Package for the escape-stuffed packet deframer.
// Holds codes, widths and the structs shared by the core, register and output modules.
// No dependencies.
`default_nettype none

package dsd_pkg;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 1;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END    = 1'd1;

	// Reset values of the registers
	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h10;
	localparam logic [BYTE_W-1:0] END_RESET    = 8'h03;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

	// Configuration seen by the core
	typedef struct packed {
		logic [BYTE_W-1:0] escape_byte;
		logic [BYTE_W-1:0] end_byte;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [BYTE_W-1:0] position;
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] out_byte;
	} res_t;

endpackage

`default_nettype wire

// ===== src/dsd_cfg_regs.sv =====
// Configuration registers of the deframer: escape byte and end byte.
// Depends on dsd_pkg.
`default_nettype none

module dsd_cfg_regs
	import dsd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_wdata,
	output cfg_t                      cfg
);

	logic [BYTE_W-1:0] escape_q;
	logic [BYTE_W-1:0] end_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= ESCAPE_RESET;
			end_q    <= END_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ESCAPE: escape_q <= cfg_wdata;
				REG_END:    end_q    <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	assign cfg.escape_byte = escape_q;
	assign cfg.end_byte    = end_q;

endmodule

`default_nettype wire

// ===== src/dsd_core.sv =====
// Deframing state machine: unstuffs one byte per cycle while adv is high, keeps checksum and body count.
// Depends on dsd_pkg.
`default_nettype none

module dsd_core
	import dsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              adv,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output logic                   res_valid,
	output res_t                   res
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_ESC  = 2'd2;

	logic [1:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] count_q, count_d;
	logic              is_esc, is_end, take;
	logic [BYTE_W-1:0] count_inc;

	assign is_esc = (rx_byte == cfg.escape_byte);
	assign is_end = (rx_byte == cfg.end_byte);
	// Saturate the body count at its top value
	assign count_inc = (count_q == {BYTE_W{1'b1}}) ? count_q : count_q + 1'b1;

	// Decode the byte against the current phase
	always_comb begin
		phase_d   = phase_q;
		take      = 1'b0;
		res_valid = 1'b0;
		res.out_byte = '0;
		res.kind     = KIND_DATA;
		res.position = count_q;
		unique case (phase_q)
			PH_BODY: begin
				if (is_esc) begin
					phase_d = PH_ESC;
				end else begin
					take = 1'b1;
				end
			end
			PH_ESC: begin
				if (is_esc) begin
					phase_d = PH_BODY;
					take    = 1'b1;
				end else begin
					phase_d   = PH_IDLE;
					res_valid = adv;
					if (is_end) begin
						res.kind = (sum_q == '0) ? KIND_GOOD : KIND_BAD;
					end else begin
						res.kind = KIND_ERR;
					end
				end
			end
			default: begin
				phase_d = is_esc ? PH_BODY : PH_IDLE;
			end
		endcase
		if (take) begin
			res_valid    = adv;
			res.out_byte = rx_byte;
		end
	end

	// Next sum and count
	always_comb begin
		sum_d   = sum_q;
		count_d = count_q;
		if (take) begin
			sum_d   = sum_q + rx_byte;
			count_d = count_inc;
		end else if (phase_q != PH_BODY && phase_q != PH_ESC && is_esc) begin
			sum_d   = '0;
			count_d = '0;
		end
	end

	// Advance state when the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sum_q   <= '0;
			count_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/dsd_out_reg.sv =====
// Output register of the deframer: holds one result item until the receiver takes it.
// Depends on dsd_pkg.
`default_nettype none

module dsd_out_reg
	import dsd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                res_valid,
	input  wire res_t                res,
	output logic                     out_free,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [2*BYTE_W-1:0]      m_tdata,
	output logic [KIND_W-1:0]        m_tuser
);

	logic valid_q;
	res_t res_q;

	assign out_free = !valid_q || m_tready;

	// Load a new result whenever the slot is empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.position, res_q.out_byte};
	assign m_tuser  = res_q.kind;

endmodule

`default_nettype wire

// ===== src/dle_stuffed_packet_deframer_unit.sv =====
// Escape-stuffed packet deframer with mod-256 checksum check.
// Input channel s_*: one raw received byte per item in s_tdata[7:0].
// Output channel m_*: m_tdata = {position, out_byte}, m_tuser = kind
//   (0 data byte, 1 end with good sum, 2 end with bad sum, 3 framing error).
// A packet opens with the escape byte; escape+escape is one data byte equal
// to the escape value, escape+end closes the packet, escape+other is an error.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 escape byte, reset 0x10; 1 end byte, reset 0x03). Write only while idle.
// Path: an accepted byte passes through the input register and is decoded into
//   the output register, which drives m_tvalid and holds the result until taken.
// Throughput: one item per cycle while the output is not stalled; the deframing state updates per advancing item.
// Reset: arst_n clears the valid flags of the input and output registers and returns to idle, waiting
//   for an escape byte; configuration registers take their reset values.
// Stall: while m_tready is low and a result waits, the input register holds
//   its byte and s_tready drops once that register is full.
// Depends on dsd_pkg, dsd_cfg_regs, dsd_core, dsd_out_reg.
`default_nettype none

module dle_stuffed_packet_deframer_unit
	import dsd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Input stream; s_tdata: [7:0] rx_byte
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [BYTE_W-1:0]    s_tdata,
	// Output stream; m_tdata: [7:0] out_byte, [15:8] position
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [2*BYTE_W-1:0]       m_tdata,
	// m_tuser: [1:0] kind
	output logic [KIND_W-1:0]         m_tuser,
	// Configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_wdata
);

	cfg_t              cfg;
	res_t              res;
	logic              res_valid;
	logic              out_free;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv;

	dsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Item in the input register moves on when the output slot can take it
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	dsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.adv       (adv),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	dsd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// A result comes only from an item that leaves the input register
	assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> adv)
		else $error("result produced without an advancing item");

	// A blocked item in the input register holds its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a blocked item");

	// Only data results carry a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_DATA) |-> (m_tdata[BYTE_W-1:0] == '0))
		else $error("non-data result carries a byte");

endmodule

`default_nettype wire
